// ===== design/buc_pkg.sv =====
// Shared types, constants and corner classification functions for the
// bilevel corner smoothing upscaler. No dependencies.
package buc_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_SCALE  = 32;
	localparam int COL_W      = 12;
	localparam int ROW_W      = 13;
	localparam int SEG_W      = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int NUM_PAT    = 12;

	localparam logic [ROW_W-1:0] ROW_MAX = '1;

	localparam logic [0:0] REG_SCALE = 1'b0;
	localparam logic [0:0] REG_WIDTH = 1'b1;

	localparam logic [1:0] CLS_NONE      = 2'd0;
	localparam logic [1:0] CLS_NORMAL    = 2'd1;
	localparam logic [1:0] CLS_REDUCED   = 2'd2;
	localparam logic [1:0] CLS_REDUCED_CO = 2'd3;

	localparam logic [15:0] PAT_WORD [NUM_PAT] = '{
		16'hd555, 16'hffc1, 16'hd514, 16'hd554, 16'hd515, 16'hbea2,
		16'hdfc0, 16'hfd81, 16'hfd80, 16'hdf80, 16'hbfa1, 16'hfec2
	};
	localparam logic [1:0] PAT_CLASS [NUM_PAT] = '{
		CLS_NONE, CLS_NORMAL, CLS_NORMAL, CLS_REDUCED, CLS_REDUCED, CLS_REDUCED,
		CLS_REDUCED, CLS_REDUCED, CLS_REDUCED, CLS_REDUCED, CLS_REDUCED_CO,
		CLS_REDUCED_CO
	};

	typedef struct packed {
		logic             pix_a;
		logic [7:0]       flag_a;
		logic             pix_b;
		logic [7:0]       flag_b;
		logic [11:0]      srow;
		logic [COL_W-1:0] col;
		logic             has_a;
		logic             has_b;
	} job_t;

	function automatic logic [1:0] classify(input logic [7:0] pat);
		logic [1:0] cls;
		logic hit;
		cls = CLS_NONE;
		hit = 1'b0;
		for (int i = 0; i < NUM_PAT; i++) begin
			if (!hit && ((pat & PAT_WORD[i][15:8]) ==
					(PAT_WORD[i][7:0] & PAT_WORD[i][15:8]))) begin
				cls = PAT_CLASS[i];
				hit = 1'b1;
			end
		end
		return cls;
	endfunction

	// Window bit 3*x+y: x column (0 left), y row (0 top).
	function automatic logic [7:0] corner_flags(input logic [8:0] w);
		logic [7:0] d;
		logic [7:0] pat;
		logic [7:0] f;
		logic [2:0] idx;
		d = {w[2], w[5], w[8], w[7], w[6], w[3], w[0], w[1]};
		f = '0;
		for (int j = 0; j < 4; j++) begin
			pat = '0;
			pat[7] = w[4];
			for (int k = 0; k < 7; k++) begin
				idx = 3'(2 * j + k);
				pat[6-k] = d[idx];
			end
			f[2*j +: 2] = classify(pat);
		end
		return f;
	endfunction

	function automatic logic [4:0] adjust(input logic [1:0] cls, input logic [4:0] cut,
			input logic [4:0] cutoff);
		logic [4:0] r;
		case (cls)
			CLS_NORMAL:     r = cut;
			CLS_REDUCED:    r = (cut != '0) ? cut - 5'd1 : 5'd0;
			CLS_REDUCED_CO: r = (cut != '0 && cutoff > 5'd1) ? cut - 5'd1 : cut;
			default:        r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [SEG_W-1:0] low_mask(input logic [5:0] n);
		logic [SEG_W-1:0] m;
		if (n[5])
			m = '1;
		else
			m = (SEG_W'(1) << n[4:0]) - SEG_W'(1);
		return m;
	endfunction

endpackage

// ===== design/buc_front.sv =====
// Front end: tracks position, keeps both line stores and the 3x3 window,
// classifies corners and queues jobs. Depends on buc_pkg.
module buc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          pixel,
	input  logic          sof,
	input  logic [12:0]   wdt,
	output logic          push,
	output buc_pkg::job_t job,
	input  logic          full
);
	import buc_pkg::*;

	logic [COL_W-1:0] col_q, col_base, c_in, c_s1, col_s2;
	logic [ROW_W-1:0] row_q, row_base, row_in, row_s1;
	logic             last_in, accept, adv1, adv2;
	logic             valid_s1, pix_s1, last_s1;
	logic             valid_s2, has_a_s2, has_b_s2;
	logic [11:0]      srow_s2;
	logic [8:0]       win_q, wbase, win_next, win_s2;
	logic [1:0]       mem [MAX_WIDTH];
	logic [1:0]       rd_q, fwd_q, line;
	logic             fwd_hit_q, up, mid;

	assign adv2     = !valid_s2 || !full;
	assign adv1     = valid_s1 && adv2;
	assign in_ready = !valid_s1 || adv2;
	assign accept   = in_valid && in_ready;
	assign push     = valid_s2 && !full;

	always_comb begin
		col_base = sof ? '0 : col_q;
		row_base = sof ? '0 : row_q;
		if ({1'b0, col_base} >= wdt) begin
			c_in   = '0;
			row_in = (row_base == ROW_MAX) ? row_base : row_base + ROW_W'(1);
		end else begin
			c_in   = col_base;
			row_in = row_base;
		end
		last_in = ({1'b0, c_in} + 13'd1) >= wdt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_in) begin
				col_q <= '0;
				row_q <= (row_in == ROW_MAX) ? row_in : row_in + ROW_W'(1);
			end else begin
				col_q <= c_in + COL_W'(1);
				row_q <= row_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel;
			c_s1    <= c_in;
			row_s1  <= row_in;
			last_s1 <= last_in;
		end
	end

	always_comb begin
		line     = fwd_hit_q ? fwd_q : rd_q;
		up       = (row_s1 >= ROW_W'(2)) & line[1];
		mid      = (row_s1 != '0) & line[0];
		wbase    = (c_s1 == '0) ? 9'd0 : win_q;
		win_next = {pix_s1, mid, up, wbase[8:3]};
	end

	always_ff @(posedge clk) begin
		if (adv1)
			mem[c_s1] <= {mid, pix_s1};
		if (accept) begin
			rd_q  <= mem[c_in];
			fwd_q <= {mid, pix_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
			win_q     <= '0;
		end else begin
			if (accept)
				fwd_hit_q <= adv1 && (c_in == c_s1);
			if (adv1)
				win_q <= win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1 && (row_s1 != '0) && ((c_s1 != '0) || last_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			win_s2   <= win_next;
			srow_s2  <= 12'(row_s1 - ROW_W'(1));
			col_s2   <= c_s1;
			has_a_s2 <= c_s1 != '0;
			has_b_s2 <= last_s1;
		end
	end

	always_comb begin
		job.pix_a  = win_s2[4];
		job.flag_a = corner_flags(win_s2);
		job.pix_b  = win_s2[7];
		job.flag_b = corner_flags({3'b000, win_s2[8:3]});
		job.srow   = srow_s2;
		job.col    = col_s2;
		job.has_a  = has_a_s2;
		job.has_b  = has_b_s2;
	end

endmodule

// ===== design/buc_fifo.sv =====
// Short job queue between the front end and the segment generator.
// Depends on buc_pkg.
module buc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  buc_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output buc_pkg::job_t rd_job,
	output logic          empty
);
	import buc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t               slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign full   = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign empty  = count_q == '0;
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/buc_back.sv =====
// Back end: expands each queued job into one segment per output subrow of each of its
// pixels, behind an output register. Depends on buc_pkg.
module buc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [5:0]                 s,
	input  logic                       empty,
	input  buc_pkg::job_t              job,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [buc_pkg::SEG_W-1:0]  seg,
	output logic [11:0]                srow,
	output logic [11:0]                scol,
	output logic [4:0]                 subrow,
	output logic                       last
);
	import buc_pkg::*;

	job_t             cur_q;
	logic             cur_valid_q, phase_q, out_valid_q;
	logic [4:0]       sub_q;
	logic             out_free, fire, fin_sub, job_end, fin_job;
	logic             pix;
	logic [7:0]       flag;
	logic [COL_W-1:0] col;
	logic [4:0]       cutoff, cut, cutl, cutr;
	logic [5:0]       ucut, i6;
	logic [1:0]       cls_l, cls_r;
	logic             in_band;
	logic [SEG_W-1:0] full_m, edge_m, seg_next;

	assign out_free  = !out_valid_q || out_ready;
	assign fire      = cur_valid_q && out_free;
	assign fin_sub   = ({1'b0, sub_q} == s - 6'd1);
	assign job_end   = fin_sub && (phase_q || !cur_q.has_b);
	assign fin_job   = fire && job_end;
	assign pop       = !empty && (!cur_valid_q || fin_job);
	assign out_valid = out_valid_q;

	always_comb begin
		pix    = phase_q ? cur_q.pix_b : cur_q.pix_a;
		flag   = phase_q ? cur_q.flag_b : cur_q.flag_a;
		col    = phase_q ? cur_q.col : cur_q.col - COL_W'(1);
		cutoff = s[5:1];
		ucut   = s - 6'd1 - {1'b0, cutoff};
		i6     = {1'b0, sub_q};
		if (i6 < {1'b0, cutoff}) begin
			in_band = 1'b1;
			cut     = cutoff - sub_q;
			cls_l   = flag[7:6];
			cls_r   = flag[1:0];
		end else if (i6 > ucut) begin
			in_band = 1'b1;
			cut     = 5'(i6 - ucut);
			cls_l   = flag[5:4];
			cls_r   = flag[3:2];
		end else begin
			in_band = 1'b0;
			cut     = '0;
			cls_l   = CLS_NONE;
			cls_r   = CLS_NONE;
		end
		cutl     = in_band ? adjust(cls_l, cut, cutoff) : 5'd0;
		cutr     = in_band ? adjust(cls_r, cut, cutoff) : 5'd0;
		full_m   = low_mask(s);
		edge_m   = low_mask({1'b0, cutl}) | (full_m & ~low_mask(s - {1'b0, cutr}));
		seg_next = ({SEG_W{pix}} & full_m) ^ (edge_m & full_m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			sub_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			phase_q     <= !job.has_a;
			sub_q       <= '0;
		end else if (fin_job) begin
			cur_valid_q <= 1'b0;
		end else if (fire) begin
			if (fin_sub) begin
				phase_q <= 1'b1;
				sub_q   <= '0;
			end else begin
				sub_q <= sub_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			seg    <= seg_next;
			srow   <= cur_q.srow;
			scol   <= 12'(col);
			subrow <= sub_q;
			last   <= job_end;
		end
	end

endmodule

// ===== design/bilevel_corner_smoothing_upscaler_core.sv =====
// Bilevel corner smoothing upscaler, top level.
// Path: front end registers, job queue, back end job register and output register to m_tdata.
// Throughput: one segment per cycle while m_tready is high and jobs are queued; a new pixel
// is taken while the job queue has room.
// Reset: asynchronous, active low; clears position, window, queue and handshake state.
// Depends on buc_pkg, buc_front, buc_fifo and buc_back.
module bilevel_corner_smoothing_upscaler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] pixel
	input  logic [0:0]  s_tuser,   // [0] start_of_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] segment_bits, [43:32] source_row,
	                               // [55:44] source_col, [60:56] subrow
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_wdata
);
	import buc_pkg::*;

	logic [5:0]       scale_q, s_eff;
	logic [12:0]      width_q, wdt_eff;
	logic             push, full, pop, empty;
	job_t             wr_job, rd_job;
	logic [SEG_W-1:0] seg;
	logic [11:0]      srow, scol;
	logic [4:0]       subrow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 6'd1;
			width_q <= 13'(MAX_WIDTH);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE: scale_q <= cfg_wdata[5:0];
				REG_WIDTH: width_q <= cfg_wdata;
				default:   scale_q <= scale_q;
			endcase
		end
	end

	always_comb begin
		if (scale_q == '0)
			s_eff = 6'd1;
		else if (scale_q > 6'(MAX_SCALE))
			s_eff = 6'(MAX_SCALE);
		else
			s_eff = scale_q;
		if (width_q == '0)
			wdt_eff = 13'd1;
		else if (width_q > 13'(MAX_WIDTH))
			wdt_eff = 13'(MAX_WIDTH);
		else
			wdt_eff = width_q;
	end

	buc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.pixel    (s_tdata[0]),
		.sof      (s_tuser[0]),
		.wdt      (wdt_eff),
		.push     (push),
		.job      (wr_job),
		.full     (full)
	);

	buc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty)
	);

	buc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.s         (s_eff),
		.empty     (empty),
		.job       (rd_job),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.seg       (seg),
		.srow      (srow),
		.scol      (scol),
		.subrow    (subrow),
		.last      (m_tlast)
	);

	assign m_tdata = {3'b000, subrow, scol, srow, seg};

	a_seg_within_scale: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((seg & ~low_mask(s_eff)) == '0))
		else $error("segment bits set beyond scale");

	a_subrow_within_scale: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, subrow} < s_eff))
		else $error("subrow beyond scale");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue read while empty");

endmodule

// ===== bench/bilevel_corner_smoothing_upscaler_core_tb.sv =====
// Testbench for bilevel_corner_smoothing_upscaler_core: streams bilevel frames, predicts every
// expanded segment with its own smoothing model and checks each transfer in order.
// Depends on buc_pkg and the upscaler RTL.
`timescale 1ns / 100ps

module bilevel_corner_smoothing_upscaler_core_tb;
	import buc_pkg::*;

	localparam int SETTLE_CYCLES = 32;
	localparam int STALL_LIMIT   = 5000;

	typedef struct packed {
		logic [31:0] bits;
		logic [11:0] srow;
		logic [11:0] scol;
		logic [4:0]  subrow;
		logic        last;
	} segment_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [0] pixel
	logic [0:0]  s_tuser;    // [0] start_of_frame
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;    // [31:0] segment_bits, [43:32] source_row,
	                         // [55:44] source_col, [60:56] subrow
	logic        m_tlast;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [12:0] cfg_wdata;

	segment_t expected_segments[$];
	int errors = 0;
	int stall_cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	logic [5:0]  scale_reg = 6'd1;
	logic [12:0] width_reg = 13'd4096;
	bit          upper_line [MAX_WIDTH];
	bit          middle_line [MAX_WIDTH];
	logic [8:0]  window_bits = '0;
	int          col_pos = 0;
	int          row_pos = 0;

	bilevel_corner_smoothing_upscaler_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [1:0] corner_class(input logic [7:0] pat);
		for (int i = 0; i < NUM_PAT; i++)
			if ((pat & PAT_WORD[i][15:8]) == (PAT_WORD[i][7:0] & PAT_WORD[i][15:8]))
				return PAT_CLASS[i];
		return CLS_NONE;
	endfunction

	function automatic int trim_cut(input logic [1:0] cls, input int cut, input int cutoff);
		case (cls)
			CLS_NORMAL:     return cut;
			CLS_REDUCED:    return (cut > 0) ? cut - 1 : 0;
			CLS_REDUCED_CO: return (cut > 0 && cutoff > 1) ? cut - 1 : cut;
			default:        return 0;
		endcase
	endfunction

	function automatic logic [63:0] ones_below(input int n);
		return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
	endfunction

	function automatic void expand_pixel(input logic [8:0] win, input int s, input int srow,
			input int scol);
		logic [7:0]  ring;
		logic [7:0]  pat;
		logic [7:0]  flags;
		logic [63:0] full;
		logic [63:0] seg;
		logic [63:0] cut_mask;
		int          cutoff;
		int          ucutoff;
		int          cutl;
		int          cutr;
		segment_t    item;
		// ring order: W NW N NE E SE S SW
		ring = {win[2], win[5], win[8], win[7], win[6], win[3], win[0], win[1]};
		flags = '0;
		for (int j = 0; j < 4; j++) begin
			pat = {win[4], 7'b0};
			for (int k = 0; k < 7; k++)
				pat[6-k] = ring[(2 * j + k) % 8];
			flags[2*j +: 2] = corner_class(pat);
		end
		cutoff = s / 2;
		ucutoff = s - 1 - cutoff;
		full = ones_below(s);
		for (int i = 0; i < s; i++) begin
			cutl = 0;
			cutr = 0;
			if (i < cutoff) begin
				cutl = trim_cut(flags[7:6], cutoff - i, cutoff);
				cutr = trim_cut(flags[1:0], cutoff - i, cutoff);
			end else if (i > ucutoff) begin
				cutl = trim_cut(flags[5:4], i - ucutoff, cutoff);
				cutr = trim_cut(flags[3:2], i - ucutoff, cutoff);
			end
			seg = win[4] ? full : '0;
			cut_mask = ones_below(cutl) | (full & ~ones_below(s - cutr));
			seg ^= cut_mask & full;
			item.bits = seg[31:0];
			item.srow = 12'(srow);
			item.scol = 12'(scol);
			item.subrow = 5'(i);
			item.last = 1'b0;
			expected_segments.push_back(item);
		end
	endfunction

	function automatic void advance_upscaler(input logic pix, input logic sof);
		int       s;
		int       w;
		int       c;
		int       queued;
		bit       up;
		bit       mid;
		segment_t tail;
		s = scale_reg;
		if (s < 1) s = 1;
		if (s > MAX_SCALE) s = MAX_SCALE;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			if (row_pos < int'(ROW_MAX)) row_pos++;
		end
		c = col_pos;
		if (c == 0) window_bits = '0;
		up = (row_pos < 2) ? 1'b0 : upper_line[c];
		mid = (row_pos < 1) ? 1'b0 : middle_line[c];
		upper_line[c] = mid;
		middle_line[c] = pix;
		window_bits = {pix, mid, up, window_bits[8:3]};
		if (row_pos >= 1) begin
			queued = expected_segments.size();
			if (c >= 1)
				expand_pixel(window_bits, s, row_pos - 1, c - 1);
			if (c + 1 == w)
				expand_pixel({3'b0, window_bits[8:3]}, s, row_pos - 1, c);
			if (expected_segments.size() > queued) begin
				tail = expected_segments.pop_back();
				tail.last = 1'b1;
				expected_segments.push_back(tail);
			end
		end
		if (c + 1 >= w) begin
			col_pos = 0;
			if (row_pos < int'(ROW_MAX)) row_pos++;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_segments
		segment_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_segments.size() == 0) begin
				$error("unexpected segment transfer: tdata %h", m_tdata);
				errors++;
			end else begin
				want = expected_segments.pop_front();
				check_field("segment_bits", want.bits, m_tdata[31:0]);
				check_field("source_row", 32'(want.srow), 32'(m_tdata[43:32]));
				check_field("source_col", 32'(want.scol), 32'(m_tdata[55:44]));
				check_field("subrow", 32'(want.subrow), 32'(m_tdata[60:56]));
				check_field("last", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic send_pixel(input logic pix, input logic sof);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {7'b0, pix};
		s_tuser = sof;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		advance_upscaler(pix, sof);
	endtask

	task automatic send_row(input logic [MAX_WIDTH-1:0] bits, input int count, input logic sof);
		for (int i = 0; i < count; i++)
			send_pixel(bits[i], sof && i == 0);
	endtask

	function automatic logic [MAX_WIDTH-1:0] random_row(input int density, input int count);
		logic [MAX_WIDTH-1:0] bits;
		bits = '0;
		for (int i = 0; i < count; i++)
			bits[i] = ($urandom_range(99) < density);
		return bits;
	endfunction

	task automatic drain_results;
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_segments.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] index, input logic [12:0] value);
		drain_results();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (index == REG_SCALE)
			scale_reg = value[5:0];
		else
			width_reg = value;
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
	endtask

	// reset values: a short first row at full width yields nothing, scale 1 is kept
	task automatic test_reset_defaults;
		send_row(random_row(50, 5), 5, 1'b1);
		write_reg(REG_WIDTH, 13'd3);
		send_row(random_row(50, 3), 3, 1'b1);
		send_row(random_row(50, 3), 3, 1'b0);
		send_row('0, 3, 1'b0);
		drain_results();
	endtask

	// the clamped width must not wrap the row early; a lower width then wraps it
	task automatic test_width_above_max;
		write_reg(REG_SCALE, 13'd3);
		write_reg(REG_WIDTH, 13'h1FFF);
		send_row(random_row(50, 6), 6, 1'b1);
		write_reg(REG_WIDTH, 13'd2);
		send_row(random_row(50, 2), 2, 1'b0);
		send_row('0, 2, 1'b0);
		drain_results();
	endtask

	task automatic test_corner_shapes;
		write_reg(REG_SCALE, 13'd7);
		write_reg(REG_WIDTH, 13'd4);
		send_row(MAX_WIDTH'(4'b0011), 4, 1'b1);
		send_row(MAX_WIDTH'(4'b0110), 4, 1'b0);
		send_row(MAX_WIDTH'(4'b1101), 4, 1'b0);
		send_row('0, 4, 1'b0);
		drain_results();
	endtask

	task automatic test_scale_limits;
		write_reg(REG_SCALE, 13'd0);
		write_reg(REG_WIDTH, 13'd0);
		send_pixel(1'b1, 1'b1);
		send_pixel(1'b0, 1'b0);
		write_reg(REG_SCALE, 13'h1FFF);
		write_reg(REG_WIDTH, 13'd2);
		send_row(MAX_WIDTH'(2'b01), 2, 1'b1);
		send_row('0, 2, 1'b0);
		write_reg(REG_SCALE, 13'd32);
		send_row(MAX_WIDTH'(2'b11), 2, 1'b1);
		send_row('0, 2, 1'b0);
		drain_results();
	endtask

	// lower the width while the column position sits beyond it; no new frame
	task automatic test_width_lowered;
		write_reg(REG_SCALE, 13'd2);
		write_reg(REG_WIDTH, 13'd4);
		send_row(random_row(50, 4), 4, 1'b1);
		send_row(random_row(50, 3), 3, 1'b0);
		write_reg(REG_WIDTH, 13'd2);
		send_row(random_row(50, 2), 2, 1'b0);
		send_row('0, 2, 1'b0);
		drain_results();
	endtask

	task automatic test_random_frames(input int count);
		int sent;
		int s;
		int w;
		int h;
		int density;
		int burst;
		bit need_sof;
		sent = 0;
		need_sof = 1'b0;
		while (sent < count) begin
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(3))
					0:       s = 1;
					1:       s = MAX_SCALE;
					default: s = $urandom_range(63);
				endcase
				write_reg(REG_SCALE, {7'($urandom), 6'(s)});
				write_reg(REG_WIDTH, 13'($urandom_range(8)));
				need_sof = 1'b1;
			end
			w = width_reg;
			if (w < 1) w = 1;
			if ($urandom_range(9) == 0) begin
				burst = $urandom_range(1, 5);
				for (int i = 0; i < burst; i++) begin
					send_pixel(1'($urandom_range(1)), need_sof || ($urandom_range(3) == 0));
					need_sof = 1'b0;
				end
				sent += burst;
			end else begin
				h = $urandom_range(1, 3);
				density = $urandom_range(10, 90);
				for (int r = 0; r < h; r++)
					send_row(random_row(density, w), w, r == 0);
				need_sof = 1'b0;
				sent += h * w;
				if ($urandom_range(6) != 0) begin
					send_row('0, w, 1'b0);
					sent += w;
				end
			end
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_idling(12, 67);
		test_reset_defaults();
		test_width_above_max();
		test_corner_shapes();
		test_scale_limits();
		test_width_lowered();
		test_random_frames(10);
		set_idling(67, 12);
		test_random_frames(10);
		set_idling(0, 0);
		test_random_frames(8);

		drain_results();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
